>>> design/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor compensation pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int NSTAGE = 8;

	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int IDX_W   = 3;
	localparam int TEMP_W  = 19;
	localparam int PRES_W  = 32;
	localparam int DT_W    = 25;
	localparam int MUL1_W  = 42;
	localparam int TD_W    = 18;
	localparam int DSQ_W   = 48;
	localparam int OFF_W   = 40;
	localparam int SENS_W  = 38;
	localparam int Q_W     = 34;
	localparam int R_W     = 35;
	localparam int T2_W    = 17;
	localparam int CORR_W  = 39;
	localparam int PROD_W  = 63;

	localparam int TEMP_REF  = 2000;
	localparam int TEMP_VLOW = -1500;
	localparam int SH_TEMP   = 23;
	localparam int SH_PROD   = 21;
	localparam int FIN_STD   = 15;
	localparam int FIN_30BAR = 13;

	localparam logic [IDX_W-1:0] REG_VARIANT = 3'd0;
	localparam logic [IDX_W-1:0] REG_C1      = 3'd1;
	localparam logic [IDX_W-1:0] REG_C2      = 3'd2;
	localparam logic [IDX_W-1:0] REG_C3      = 3'd3;
	localparam logic [IDX_W-1:0] REG_C4      = 3'd4;
	localparam logic [IDX_W-1:0] REG_C5      = 3'd5;
	localparam logic [IDX_W-1:0] REG_C6      = 3'd6;

	localparam logic [1:0] VAR_14BAR = 2'd0;
	localparam logic [1:0] VAR_30BAR = 2'd1;
	localparam logic [1:0] VAR_2BAR  = 2'd2;

	typedef struct packed {
		logic [1:0]        variant;
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] c3;
		logic [COEF_W-1:0] c4;
		logic [COEF_W-1:0] c5;
		logic [COEF_W-1:0] c6;
	} cfg_t;

	typedef struct packed {
		logic [NSTAGE-1:0] en;
	} ctl_t;

	typedef struct packed {
		logic [RAW_W-1:0]        d1;
		logic signed [TD_W-1:0]  tdelta;
		logic signed [OFF_W-1:0] off1;
		logic signed [OFF_W-1:0] sens1;
		logic [DSQ_W-1:0]        dsq;
		logic                    cold;
		logic                    vcold;
	} s3_t;

	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} s6_t;

endpackage

>>> design/psc_in_if.sv
// ----------------------------------------------------------------------------
// psc_in_if
// Raw conversion channel: one pressure / temperature pair per transaction.
// ----------------------------------------------------------------------------
interface psc_in_if;
	logic                       valid;
	logic                       ready;
	logic [psc_pkg::RAW_W-1:0]  raw_pressure;
	logic [psc_pkg::RAW_W-1:0]  raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

>>> design/psc_out_if.sv
// ----------------------------------------------------------------------------
// psc_out_if
// Compensated result channel: temperature and pressure per transaction.
// ----------------------------------------------------------------------------
interface psc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [psc_pkg::TEMP_W-1:0]  temperature_centi;
	logic signed [psc_pkg::PRES_W-1:0]  pressure_count;

	modport source (output valid, output temperature_centi, output pressure_count, input ready);
	modport sink (input valid, input temperature_centi, input pressure_count, output ready);
endinterface

>>> design/psc_cfg.sv
// ----------------------------------------------------------------------------
// psc_cfg
// Calibration and variant registers behind a plain write port.
// ----------------------------------------------------------------------------
module psc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [psc_pkg::COEF_W-1:0]  cfg_data,
	output psc_pkg::cfg_t               cfg
);

	psc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= '0;
			cfg_q.variant <= psc_pkg::VAR_30BAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psc_pkg::REG_VARIANT: cfg_q.variant <= cfg_data[1:0];
				psc_pkg::REG_C1:      cfg_q.c1 <= cfg_data;
				psc_pkg::REG_C2:      cfg_q.c2 <= cfg_data;
				psc_pkg::REG_C3:      cfg_q.c3 <= cfg_data;
				psc_pkg::REG_C4:      cfg_q.c4 <= cfg_data;
				psc_pkg::REG_C5:      cfg_q.c5 <= cfg_data;
				psc_pkg::REG_C6:      cfg_q.c6 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Stage valid bits and per-stage load enables; bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module psc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_ready,
	output logic           in_ready,
	output logic           out_valid,
	output psc_pkg::ctl_t  ctl
);

	logic [psc_pkg::NSTAGE-1:0] vld_q;
	logic [psc_pkg::NSTAGE-1:0] en;

	always_comb begin
		en[psc_pkg::NSTAGE-1] = !vld_q[psc_pkg::NSTAGE-1] || out_ready;
		for (int k = psc_pkg::NSTAGE - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < psc_pkg::NSTAGE; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en    = en;
	assign in_ready  = en[0];
	assign out_valid = vld_q[psc_pkg::NSTAGE-1];

endmodule

>>> design/psc_first.sv
// ----------------------------------------------------------------------------
// psc_first
// Stages 1-3: temperature difference, first-order products, OFF and SENS.
// ----------------------------------------------------------------------------
module psc_first (
	input  logic                       clk,
	input  psc_pkg::cfg_t              cfg,
	input  psc_pkg::ctl_t              ctl,
	input  logic [psc_pkg::RAW_W-1:0]  raw_pressure,
	input  logic [psc_pkg::RAW_W-1:0]  raw_temperature,
	output psc_pkg::s3_t               s3
);

	logic                              two_bar;

	logic [psc_pkg::RAW_W-1:0]         d1_s1, d1_s2, d1_s3;
	logic signed [psc_pkg::DT_W-1:0]   dt_s1;

	logic signed [psc_pkg::MUL1_W-1:0] dtc6_s2, c4dt_s2, c3dt_s2;
	logic signed [2*psc_pkg::DT_W-1:0] dsq_full;
	logic [psc_pkg::DSQ_W-1:0]         dsq_s2, dsq_s3;

	logic signed [psc_pkg::MUL1_W-1:0] tsh, c4sh, c3sh;
	logic signed [psc_pkg::TD_W-1:0]   tdelta;
	logic signed [psc_pkg::OFF_W-1:0]  off_base, sens_base;
	logic signed [psc_pkg::TD_W-1:0]   tdelta_s3;
	logic signed [psc_pkg::OFF_W-1:0]  off1_s3, sens1_s3;
	logic                              cold_s3, vcold_s3;

	assign two_bar = (cfg.variant == psc_pkg::VAR_2BAR);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.c5, 8'h00});
		end
	end

	assign dsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			d1_s2   <= d1_s1;
			dtc6_s2 <= dt_s1 * $signed({1'b0, cfg.c6});
			c4dt_s2 <= dt_s1 * $signed({1'b0, cfg.c4});
			c3dt_s2 <= dt_s1 * $signed({1'b0, cfg.c3});
			dsq_s2  <= dsq_full[psc_pkg::DSQ_W-1:0];
		end
	end

	always_comb begin
		tsh       = dtc6_s2 >>> psc_pkg::SH_TEMP;
		tdelta    = tsh[psc_pkg::TD_W-1:0];
		c4sh      = two_bar ? (c4dt_s2 >>> 6) : (c4dt_s2 >>> 7);
		c3sh      = two_bar ? (c3dt_s2 >>> 7) : (c3dt_s2 >>> 8);
		off_base  = two_bar ? $signed({7'b0, cfg.c2, 17'b0}) : $signed({8'b0, cfg.c2, 16'b0});
		sens_base = two_bar ? $signed({8'b0, cfg.c1, 16'b0}) : $signed({9'b0, cfg.c1, 15'b0});
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			d1_s3     <= d1_s2;
			tdelta_s3 <= tdelta;
			off1_s3   <= off_base + c4sh[psc_pkg::OFF_W-1:0];
			sens1_s3  <= sens_base + c3sh[psc_pkg::OFF_W-1:0];
			dsq_s3    <= dsq_s2;
			cold_s3   <= tdelta[psc_pkg::TD_W-1];
			vcold_s3  <= tdelta <
				$signed(psc_pkg::TD_W'(psc_pkg::TEMP_VLOW - psc_pkg::TEMP_REF));
		end
	end

	assign s3.d1     = d1_s3;
	assign s3.tdelta = tdelta_s3;
	assign s3.off1   = off1_s3;
	assign s3.sens1  = sens1_s3;
	assign s3.dsq    = dsq_s3;
	assign s3.cold   = cold_s3;
	assign s3.vcold  = vcold_s3;

endmodule

>>> design/psc_second.sv
// ----------------------------------------------------------------------------
// psc_second
// Stages 4-6: second-order terms per variant and temperature branch,
// then final TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module psc_second (
	input  logic           clk,
	input  psc_pkg::cfg_t  cfg,
	input  psc_pkg::ctl_t  ctl,
	input  psc_pkg::s3_t   s3,
	output psc_pkg::s6_t   s6
);

	logic                                two_bar, fourteen;

	logic signed [psc_pkg::TD_W-1:0]     td;
	logic signed [2*psc_pkg::TD_W-1:0]   q_full;
	logic signed [psc_pkg::TEMP_W-1:0]   rb;
	logic signed [2*psc_pkg::TEMP_W-1:0] r_full;
	logic signed [psc_pkg::TEMP_W-1:0]   temp1;
	logic [psc_pkg::DSQ_W+2:0]           dsq7;
	logic [psc_pkg::T2_W-1:0]            t2;

	logic [psc_pkg::RAW_W-1:0]           d1_s4, d1_s5, d1_s6;
	logic signed [psc_pkg::TEMP_W-1:0]   temp1_s4, temp1_s5, temp_s6;
	logic signed [psc_pkg::OFF_W-1:0]    off1_s4, off1_s5, off_s6;
	logic signed [psc_pkg::OFF_W-1:0]    sens1_s4, sens1_s5;
	logic signed [psc_pkg::SENS_W-1:0]   sens_s6;
	logic                                cold_s4, vcold_s4;
	logic [psc_pkg::Q_W-1:0]             q_s4;
	logic [psc_pkg::R_W-1:0]             r_s4;
	logic [psc_pkg::T2_W-1:0]            t2_s4, t2_s5;

	logic [psc_pkg::CORR_W-1:0]          qx, rx, offa, offb, sensa, sensb;
	logic [psc_pkg::CORR_W+1:0]          q63;
	logic [psc_pkg::CORR_W-1:0]          offa_s5, offb_s5, sensa_s5, sensb_s5;
	logic signed [psc_pkg::OFF_W-1:0]    sens_w;

	assign two_bar  = (cfg.variant == psc_pkg::VAR_2BAR);
	assign fourteen = (cfg.variant == psc_pkg::VAR_14BAR);

	always_comb begin
		td     = $signed(s3.tdelta);
		q_full = td * td;
		rb     = psc_pkg::TEMP_W'(td) + psc_pkg::TEMP_W'(psc_pkg::TEMP_REF - psc_pkg::TEMP_VLOW);
		r_full = rb * rb;
		temp1  = psc_pkg::TEMP_W'(td) + psc_pkg::TEMP_W'(psc_pkg::TEMP_REF);
		dsq7   = (psc_pkg::DSQ_W+3)'(s3.dsq) * (psc_pkg::DSQ_W+3)'(7);
		if (two_bar) begin
			t2 = s3.cold ? psc_pkg::T2_W'(s3.dsq >> 35) * psc_pkg::T2_W'(3) : '0;
		end else if (s3.cold) begin
			t2 = psc_pkg::T2_W'(s3.dsq >> 33) * psc_pkg::T2_W'(3);
		end else if (fourteen) begin
			t2 = psc_pkg::T2_W'(dsq7 >> 37);
		end else begin
			t2 = psc_pkg::T2_W'(s3.dsq >> 37) << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			d1_s4    <= s3.d1;
			temp1_s4 <= temp1;
			off1_s4  <= s3.off1;
			sens1_s4 <= s3.sens1;
			cold_s4  <= s3.cold;
			vcold_s4 <= s3.vcold;
			q_s4     <= q_full[psc_pkg::Q_W-1:0];
			r_s4     <= r_full[psc_pkg::R_W-1:0];
			t2_s4    <= t2;
		end
	end

	always_comb begin
		qx  = psc_pkg::CORR_W'(q_s4);
		rx  = psc_pkg::CORR_W'(r_s4);
		q63 = (psc_pkg::CORR_W+2)'(q_s4) * (psc_pkg::CORR_W+2)'(63);
		if (two_bar) begin
			offa  = cold_s4 ? ((qx * psc_pkg::CORR_W'(3)) >> 3) : '0;
			sensa = cold_s4 ? psc_pkg::CORR_W'(q63 >> 5) : '0;
		end else if (cold_s4) begin
			offa  = (qx * psc_pkg::CORR_W'(3)) >> 1;
			sensa = (qx * psc_pkg::CORR_W'(5)) >> 3;
		end else begin
			offa  = qx >> 4;
			sensa = '0;
		end
		offb  = (!two_bar && vcold_s4) ? rx * psc_pkg::CORR_W'(7) : '0;
		sensb = (!two_bar && vcold_s4) ? rx << 2 : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			d1_s5    <= d1_s4;
			temp1_s5 <= temp1_s4;
			t2_s5    <= t2_s4;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			offa_s5  <= offa;
			offb_s5  <= offb;
			sensa_s5 <= sensa;
			sensb_s5 <= sensb;
		end
	end

	assign sens_w = sens1_s5 - $signed({1'b0, sensa_s5}) - $signed({1'b0, sensb_s5});

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			d1_s6   <= d1_s5;
			temp_s6 <= temp1_s5 - $signed({2'b0, t2_s5});
			off_s6  <= off1_s5 - $signed({1'b0, offa_s5}) - $signed({1'b0, offb_s5});
			sens_s6 <= sens_w[psc_pkg::SENS_W-1:0];
		end
	end

	assign s6.d1   = d1_s6;
	assign s6.temp = temp_s6;
	assign s6.off  = off_s6;
	assign s6.sens = sens_s6;

endmodule

>>> design/psc_press.sv
// ----------------------------------------------------------------------------
// psc_press
// Stages 7-8: SENS times raw pressure, offset removal, final shift and
// saturation to 32 bits; stage 8 is the output register.
// ----------------------------------------------------------------------------
module psc_press (
	input  logic                              clk,
	input  psc_pkg::cfg_t                     cfg,
	input  psc_pkg::ctl_t                     ctl,
	input  psc_pkg::s6_t                      s6,
	output logic signed [psc_pkg::TEMP_W-1:0] temperature_centi,
	output logic signed [psc_pkg::PRES_W-1:0] pressure_count
);

	localparam int DIFF_W = psc_pkg::PROD_W - psc_pkg::SH_PROD + 1;

	logic                               std_shift;
	logic signed [psc_pkg::PROD_W-1:0]  prod_s7;
	logic signed [psc_pkg::TEMP_W-1:0]  temp_s7, temp_s8;
	logic signed [psc_pkg::OFF_W-1:0]   off_s7;
	logic signed [psc_pkg::PRES_W-1:0]  pres_s8;

	logic signed [psc_pkg::PROD_W-1:0]  psh;
	logic signed [DIFF_W-1:0]           diff, dsh;
	logic signed [psc_pkg::PRES_W-1:0]  pres;

	assign std_shift = (cfg.variant == psc_pkg::VAR_14BAR) || (cfg.variant == psc_pkg::VAR_2BAR);

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			prod_s7 <= $signed(s6.sens) * $signed({1'b0, s6.d1});
			temp_s7 <= s6.temp;
			off_s7  <= s6.off;
		end
	end

	always_comb begin
		psh  = prod_s7 >>> psc_pkg::SH_PROD;
		diff = DIFF_W'(psh) - DIFF_W'(off_s7);
		dsh  = std_shift ? (diff >>> psc_pkg::FIN_STD) : (diff >>> psc_pkg::FIN_30BAR);
		if ((&dsh[DIFF_W-1:psc_pkg::PRES_W-1]) || !(|dsh[DIFF_W-1:psc_pkg::PRES_W-1])) begin
			pres = dsh[psc_pkg::PRES_W-1:0];
		end else begin
			pres = {dsh[DIFF_W-1], {(psc_pkg::PRES_W-1){!dsh[DIFF_W-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			temp_s8 <= temp_s7;
			pres_s8 <= pres;
		end
	end

	assign temperature_centi = temp_s8;
	assign pressure_count    = pres_s8;

endmodule

>>> design/pressure_sensor_compensation_top.sv
// An accepted raw transaction passes through all 8 stages to a valid result.
// Throughput: one transaction per cycle while the result side accepts it.
// A stalled result holds only the occupied stages up to the first empty one.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// registers with variant 30-bar and all calibration words zero.
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_top
// Second-order temperature compensation of raw pressure and temperature
// conversions for three sensor variants.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_top (
	input  logic                        clk,
	input  logic                        arst_n,
	psc_in_if.sink                      raw,
	psc_out_if.source                   comp,
	input  logic                        cfg_we,
	input  logic [psc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [psc_pkg::COEF_W-1:0]  cfg_data
);

	psc_pkg::cfg_t cfg;
	psc_pkg::ctl_t ctl;
	psc_pkg::s3_t  s3;
	psc_pkg::s6_t  s6;

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (raw.valid),
		.out_ready (comp.ready),
		.in_ready  (raw.ready),
		.out_valid (comp.valid),
		.ctl       (ctl)
	);

	psc_first u_first (
		.clk             (clk),
		.cfg             (cfg),
		.ctl             (ctl),
		.raw_pressure    (raw.raw_pressure),
		.raw_temperature (raw.raw_temperature),
		.s3              (s3)
	);

	psc_second u_second (
		.clk (clk),
		.cfg (cfg),
		.ctl (ctl),
		.s3  (s3),
		.s6  (s6)
	);

	psc_press u_press (
		.clk               (clk),
		.cfg               (cfg),
		.ctl               (ctl),
		.s6                (s6),
		.temperature_centi (comp.temperature_centi),
		.pressure_count    (comp.pressure_count)
	);

`ifndef SYNTHESIS
	a_drain_admits: assert property (@(posedge clk) disable iff (!arst_n)
		comp.ready |-> raw.ready)
		else $error("raw channel blocked while result side is ready");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!raw.ready |-> (comp.valid && !comp.ready))
		else $error("raw channel blocked without a stalled result");
`endif

endmodule

>>> dv/pressure_sensor_compensation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_top_tb
// Self-checking bench for the compensation pipeline. A scoreboard recomputes
// temperature and pressure in 64-bit integer arithmetic from its own copy of
// the calibration registers and compares every result transaction in order.
// Directed probes hit the branch boundaries and code extremes, then random
// phases sweep all variants with random stalls on both channels.
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [psc_pkg::TEMP_W-1:0] temp;
	logic signed [psc_pkg::PRES_W-1:0] pres;
} reading_t;

class reading_checker;
	psc_pkg::cfg_t regs;
	reading_t      pending_readings[$];
	int            errors;
	int            pairs;
	int            readings;
	int            very_cold;
	int            cold;
	int            warm;

	function new();
		regs = '0;
		regs.variant = psc_pkg::VAR_30BAR;
		errors = 0;
		pairs = 0;
		readings = 0;
		very_cold = 0;
		cold = 0;
		warm = 0;
	endfunction

	function void load_reg(logic [psc_pkg::IDX_W-1:0] idx, logic [psc_pkg::COEF_W-1:0] data);
		case (idx)
			psc_pkg::REG_VARIANT: regs.variant = data[1:0];
			psc_pkg::REG_C1:      regs.c1 = data;
			psc_pkg::REG_C2:      regs.c2 = data;
			psc_pkg::REG_C3:      regs.c3 = data;
			psc_pkg::REG_C4:      regs.c4 = data;
			psc_pkg::REG_C5:      regs.c5 = data;
			psc_pkg::REG_C6:      regs.c6 = data;
			default: ;
		endcase
	endfunction

	function reading_t compensate(logic [psc_pkg::RAW_W-1:0] d1_raw,
			logic [psc_pkg::RAW_W-1:0] d2_raw);
		longint   d1, d2, c1, c2, c3, c4, c5, c6;
		longint   dt, temp, off, sens, t2, off2, sens2, q, r, dsq, p;
		int       fin;
		reading_t res;
		d1 = longint'(d1_raw);
		d2 = longint'(d2_raw);
		c1 = longint'(regs.c1);
		c2 = longint'(regs.c2);
		c3 = longint'(regs.c3);
		c4 = longint'(regs.c4);
		c5 = longint'(regs.c5);
		c6 = longint'(regs.c6);

		dt = d2 - c5 * 256;
		temp = ((dt * c6) >>> psc_pkg::SH_TEMP) + psc_pkg::TEMP_REF;
		if (regs.variant == psc_pkg::VAR_2BAR) begin
			off = c2 * 131072 + ((c4 * dt) >>> 6);
			sens = c1 * 65536 + ((c3 * dt) >>> 7);
		end else begin
			off = c2 * 65536 + ((c4 * dt) >>> 7);
			sens = c1 * 32768 + ((c3 * dt) >>> 8);
		end

		dsq = dt * dt;
		q = (temp - psc_pkg::TEMP_REF) * (temp - psc_pkg::TEMP_REF);
		r = (temp - psc_pkg::TEMP_VLOW) * (temp - psc_pkg::TEMP_VLOW);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		fin = psc_pkg::FIN_STD;
		if (regs.variant == psc_pkg::VAR_2BAR) begin
			if (temp < psc_pkg::TEMP_REF) begin
				t2 = 3 * (dsq >>> 35);
				off2 = (3 * q) >>> 3;
				sens2 = (63 * q) >>> 5;
			end
		end else begin
			if (temp < psc_pkg::TEMP_REF) begin
				t2 = 3 * (dsq >>> 33);
				off2 = (3 * q) >>> 1;
				sens2 = (5 * q) >>> 3;
				if (temp < psc_pkg::TEMP_VLOW) begin
					off2 += 7 * r;
					sens2 += 4 * r;
				end
			end else if (regs.variant == psc_pkg::VAR_14BAR) begin
				t2 = (7 * dsq) >>> 37;
				off2 = q >>> 4;
			end else begin
				t2 = 2 * (dsq >>> 37);
				off2 = q >>> 4;
			end
			if (regs.variant != psc_pkg::VAR_14BAR)
				fin = psc_pkg::FIN_30BAR;
		end

		if (temp < psc_pkg::TEMP_VLOW)
			very_cold++;
		else if (temp < psc_pkg::TEMP_REF)
			cold++;
		else
			warm++;

		temp -= t2;
		off -= off2;
		sens -= sens2;
		p = (((sens * d1) >>> psc_pkg::SH_PROD) - off) >>> fin;
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;

		res.temp = temp[psc_pkg::TEMP_W-1:0];
		res.pres = p[psc_pkg::PRES_W-1:0];
		return res;
	endfunction

	function void note_pair(logic [psc_pkg::RAW_W-1:0] d1_raw,
			logic [psc_pkg::RAW_W-1:0] d2_raw);
		pending_readings.push_back(compensate(d1_raw, d2_raw));
		pairs++;
	endfunction

	function void check_reading(logic signed [psc_pkg::TEMP_W-1:0] temp,
			logic signed [psc_pkg::PRES_W-1:0] pres);
		reading_t want;
		readings++;
		if (pending_readings.size() == 0) begin
			$error("unexpected result transaction: temperature_centi %0d pressure_count %0d",
				temp, pres);
			errors++;
		end else begin
			want = pending_readings.pop_front();
			if (want.temp !== temp) begin
				$error("temperature_centi mismatch: expected %0d, actual %0d", want.temp, temp);
				errors++;
			end
			if (want.pres !== pres) begin
				$error("pressure_count mismatch: expected %0d, actual %0d", want.pres, pres);
				errors++;
			end
		end
	endfunction
endclass

module pressure_sensor_compensation_top_tb;

	localparam logic [psc_pkg::IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [1:0] VAR_SPARE = 2'd3;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 100;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [psc_pkg::IDX_W-1:0]    cfg_index;
	logic [psc_pkg::COEF_W-1:0]   cfg_data;

	psc_in_if  raw_bus();
	psc_out_if comp_bus();

	reading_checker board;
	int             src_gap_pct;
	int             sink_stall_pct;
	int             settings;
	int             quiet_cycles;

	pressure_sensor_compensation_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw_bus),
		.comp      (comp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : sink_side
		int stall_left;
		stall_left = 0;
		comp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				comp_bus.ready <= 1'b0;
				stall_left--;
			end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				comp_bus.ready <= 1'b0;
				stall_left = $urandom_range(0, 17);
			end else begin
				comp_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (comp_bus.valid && comp_bus.ready)
				board.check_reading(comp_bus.temperature_centi, comp_bus.pressure_count);
			if (raw_bus.valid && raw_bus.ready)
				board.note_pair(raw_bus.raw_pressure, raw_bus.raw_temperature);
		end
	end

	always @(posedge clk) begin
		if ((raw_bus.valid && raw_bus.ready) || (comp_bus.valid && comp_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int pick_gap();
		if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct)
			return $urandom_range(1, 18);
		return 0;
	endfunction

	function automatic logic [psc_pkg::RAW_W-1:0] pick_pressure();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hffffff;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [psc_pkg::RAW_W-1:0] pick_temperature();
		int centre;
		int span;
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hffffff;
			2, 3: begin
				span = 1 << $urandom_range(4, 22);
				centre = int'(board.regs.c5) * 256 + int'($urandom_range(0, 2 * span)) - span;
				if (centre < 0)
					centre = 0;
				if (centre > 24'hffffff)
					centre = 24'hffffff;
				return 24'(centre);
			end
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [psc_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [psc_pkg::IDX_W-1:0] idx, logic [psc_pkg::COEF_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		board.load_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic program_regs(psc_pkg::cfg_t cfg);
		write_reg(psc_pkg::REG_VARIANT, {14'($urandom), cfg.variant});
		write_reg(psc_pkg::REG_C1, cfg.c1);
		write_reg(psc_pkg::REG_C2, cfg.c2);
		write_reg(psc_pkg::REG_C3, cfg.c3);
		write_reg(psc_pkg::REG_C4, cfg.c4);
		write_reg(psc_pkg::REG_C5, cfg.c5);
		write_reg(psc_pkg::REG_C6, cfg.c6);
		write_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic send_pair(logic [psc_pkg::RAW_W-1:0] pressure,
			logic [psc_pkg::RAW_W-1:0] temperature, int gap);
		if (gap > 0) begin
			raw_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		raw_bus.valid <= 1'b1;
		raw_bus.raw_pressure <= pressure;
		raw_bus.raw_temperature <= temperature;
		@(posedge clk);
		while (!raw_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		raw_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (board.pending_readings.size() != 0);
	endtask

	// reference point, one count below it, coldest and hottest raw codes
	task automatic probe_setting(psc_pkg::cfg_t cfg);
		logic [psc_pkg::RAW_W-1:0] centre;
		program_regs(cfg);
		centre = {cfg.c5, 8'h00};
		send_pair(24'h000000, centre, pick_gap());
		send_pair(24'hffffff, centre - 24'd1, pick_gap());
		send_pair(24'h800000, 24'h000000, pick_gap());
		send_pair(24'($urandom), 24'hffffff, pick_gap());
		drain();
	endtask

	task automatic run_directed();
		psc_pkg::cfg_t cfg;
		src_gap_pct = 10;
		sink_stall_pct = 10;

		send_pair(24'h000000, 24'h000000, 0);
		send_pair(24'hffffff, 24'hffffff, pick_gap());
		send_pair(24'hffffff, 24'h000000, pick_gap());
		send_pair(24'h000000, 24'hffffff, pick_gap());
		drain();

		cfg.variant = psc_pkg::VAR_14BAR;
		cfg.c1 = 16'd46372;
		cfg.c2 = 16'd43981;
		cfg.c3 = 16'd29059;
		cfg.c4 = 16'd27842;
		cfg.c5 = 16'd31553;
		cfg.c6 = 16'd28165;
		probe_setting(cfg);
		cfg.variant = psc_pkg::VAR_2BAR;
		probe_setting(cfg);
		cfg.variant = VAR_SPARE;
		probe_setting(cfg);

		cfg.c1 = 16'hffff;
		cfg.c2 = 16'hffff;
		cfg.c3 = 16'hffff;
		cfg.c4 = 16'hffff;
		cfg.c5 = 16'hffff;
		cfg.c6 = 16'hffff;
		cfg.variant = psc_pkg::VAR_30BAR;
		probe_setting(cfg);
		cfg.variant = psc_pkg::VAR_2BAR;
		probe_setting(cfg);
	endtask

	task automatic run_phase(int idx, bit calm);
		psc_pkg::cfg_t cfg;
		int            mode;
		int            pause_at;
		int            rates[4];
		rates = '{0, 5, 15, 40};
		mode = $urandom_range(0, 5);
		cfg.variant = 2'(idx % 4);
		cfg.c1 = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hffff : pick_coef();
		cfg.c2 = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hffff : pick_coef();
		cfg.c3 = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hffff : pick_coef();
		cfg.c4 = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hffff : pick_coef();
		cfg.c5 = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hffff : pick_coef();
		cfg.c6 = (mode == 0) ? 16'h0000 : (mode == 1) ? 16'hffff : pick_coef();
		if (calm) begin
			src_gap_pct = 0;
			sink_stall_pct = 0;
		end else begin
			src_gap_pct = rates[$urandom_range(0, 3)];
			sink_stall_pct = rates[$urandom_range(0, 3)];
		end
		program_regs(cfg);

		// hold the sender mid-phase until the pipeline is empty
		pause_at = (!calm && (idx == 1 || $urandom_range(0, 2) == 0)) ?
			$urandom_range(20, 80) : -1;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == pause_at)
				drain();
			send_pair(pick_pressure(), pick_temperature(), pick_gap());
		end
		drain();
	endtask

	initial begin
		board = new();
		settings = 1;
		quiet_cycles = 0;
		src_gap_pct = 0;
		sink_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		raw_bus.valid = 1'b0;
		raw_bus.raw_pressure = '0;
		raw_bus.raw_temperature = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		for (int ph = 0; ph < PHASES; ph++)
			run_phase(ph, ph == PHASES - 1);

		repeat (2 * psc_pkg::NSTAGE) @(negedge clk);
		if (board.pending_readings.size() != 0) begin
			$error("%0d expected results never arrived", board.pending_readings.size());
			board.errors++;
		end

		$display("Checked %0d results from %0d raw pairs over %0d register settings.",
			board.readings, board.pairs, settings);
		$display("Temperature branches: %0d very cold, %0d cold, %0d warm.",
			board.very_cold, board.cold, board.warm);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
design/psc_pkg.sv
design/psc_in_if.sv
design/psc_out_if.sv
design/psc_cfg.sv
design/psc_ctrl.sv
design/psc_first.sv
design/psc_second.sv
design/psc_press.sv
design/pressure_sensor_compensation_top.sv
dv/pressure_sensor_compensation_top_tb.sv
